// File: rtl/mi3_pkg.sv
package mi3_pkg;

	// entry format and derived widths
	localparam int ENTRY_W   = 32;
	localparam int FRAC_BITS = 16;
	localparam int PW        = 2 * ENTRY_W;                 // minor product
	localparam int CW        = PW + 1;                      // cofactor, signed
	localparam int PLW       = 2 * ENTRY_W + 1;             // det partial product
	localparam int DW        = 3 * ENTRY_W + 2;             // determinant, signed
	localparam int NW        = CW + 2 * FRAC_BITS;          // scaled numerator
	localparam int HW        = NW - ENTRY_W;                // numerator above quotient bits
	localparam int XW        = (HW > DW) ? HW : DW;         // overflow compare width
	localparam int NCOF      = 9;
	localparam int CNTW      = $clog2(ENTRY_W);

	// queue between front and back
	localparam int QDEPTH    = 8;
	localparam int QAW       = $clog2(QDEPTH);
	localparam int OCW       = $clog2(QDEPTH + 1);

	typedef logic signed [ENTRY_W-1:0] entry_t;

	typedef struct packed {
		entry_t m00;
		entry_t m01;
		entry_t m02;
		entry_t m10;
		entry_t m11;
		entry_t m12;
		entry_t m20;
		entry_t m21;
		entry_t m22;
	} in_word_t;

	typedef struct packed {
		entry_t inv00;
		entry_t inv01;
		entry_t inv02;
		entry_t inv10;
		entry_t inv11;
		entry_t inv12;
		entry_t inv20;
		entry_t inv21;
		entry_t inv22;
		entry_t determinant;
		logic   singular;
	} out_word_t;

	// word handed from front to back
	typedef struct packed {
		logic [NCOF-1:0][CW-1:0] cof;       // cof[3*row+col], signed
		logic [DW-1:0]           det_mag;
		logic                    det_neg;
		logic                    singular;
		entry_t                  det_field;
	} fe_word_t;

	// row/column picks for a 2x2 minor
	function automatic int lo_idx(input int i);
		return (i == 0) ? 1 : 0;
	endfunction

	function automatic int hi_idx(input int i);
		return (i == 2) ? 1 : 2;
	endfunction

	// sign and clamp a magnitude; big flags a magnitude beyond ENTRY_W bits
	function automatic entry_t sat_entry(input logic neg, input logic big,
			input logic [ENTRY_W-1:0] mag);
		logic over;
		over = big | mag[ENTRY_W-1];
		if (neg)
			return over ? entry_t'({1'b1, {(ENTRY_W-1){1'b0}}}) : entry_t'(-mag);
		else
			return over ? entry_t'({1'b0, {(ENTRY_W-1){1'b1}}}) : entry_t'(mag);
	endfunction

endpackage

// File: rtl/mi3_front.sv
module mi3_front import mi3_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     v_in,
	input  in_word_t mat,
	output logic     v_out,
	output fe_word_t word
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	entry_t                m_s1   [3][3];
	logic signed [PW-1:0]  pa_s2  [3][3];
	logic signed [PW-1:0]  pb_s2  [3][3];
	entry_t                m0_s2  [3];
	logic signed [CW-1:0]  cof_s3 [3][3];
	entry_t                m0_s3  [3];
	logic signed [PLW-1:0] pl_s4  [3];
	logic signed [PLW-1:0] ph_s4  [3];
	logic signed [CW-1:0]  cof_s4 [3][3];
	logic signed [DW-1:0]  det_s5;
	logic signed [DW-1:0]  det_sum;
	logic signed [CW-1:0]  cof_s5 [3][3];
	fe_word_t              word_s6;

	logic [DW-1:0] det_mag;
	logic [DW-1:0] det_shr;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// determinant sum of the row-0 expansion
	always_comb begin
		det_sum = '0;
		for (int j = 0; j < 3; j++)
			det_sum = det_sum + (DW'(ph_s4[j]) <<< ENTRY_W) + DW'(pl_s4[j]);
	end

	// magnitude and truncated output of the determinant
	assign det_mag = det_s5[DW-1] ? DW'(-det_s5) : DW'(det_s5);
	assign det_shr = det_mag >> (2 * FRAC_BITS);

	// datapath stages
	always_ff @(posedge clk) begin
		// s1: capture matrix
		m_s1[0][0] <= mat.m00;
		m_s1[0][1] <= mat.m01;
		m_s1[0][2] <= mat.m02;
		m_s1[1][0] <= mat.m10;
		m_s1[1][1] <= mat.m11;
		m_s1[1][2] <= mat.m12;
		m_s1[2][0] <= mat.m20;
		m_s1[2][1] <= mat.m21;
		m_s1[2][2] <= mat.m22;

		// s2: minor products
		for (int i = 0; i < 3; i++) begin
			m0_s2[i] <= m_s1[0][i];
			for (int j = 0; j < 3; j++) begin
				pa_s2[i][j] <= PW'(m_s1[lo_idx(i)][lo_idx(j)]) *
					PW'(m_s1[hi_idx(i)][hi_idx(j)]);
				pb_s2[i][j] <= PW'(m_s1[lo_idx(i)][hi_idx(j)]) *
					PW'(m_s1[hi_idx(i)][lo_idx(j)]);
			end
		end

		// s3: signed cofactors
		for (int i = 0; i < 3; i++) begin
			m0_s3[i] <= m0_s2[i];
			for (int j = 0; j < 3; j++) begin
				if (((i + j) & 1) != 0)
					cof_s3[i][j] <= CW'(pb_s2[i][j]) - CW'(pa_s2[i][j]);
				else
					cof_s3[i][j] <= CW'(pa_s2[i][j]) - CW'(pb_s2[i][j]);
			end
		end

		// s4: row-0 products, cofactor split into low and high halves
		for (int j = 0; j < 3; j++) begin
			pl_s4[j] <= PLW'(m0_s3[j]) *
				PLW'($signed({1'b0, cof_s3[0][j][ENTRY_W-1:0]}));
			ph_s4[j] <= PLW'(m0_s3[j]) * PLW'($signed(cof_s3[0][j][CW-1:ENTRY_W]));
		end
		cof_s4 <= cof_s3;

		// s5: determinant
		det_s5 <= det_sum;
		cof_s5 <= cof_s4;

		// s6: classify and pack
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				word_s6.cof[3*i+j] <= cof_s5[i][j];
		word_s6.det_mag   <= det_mag;
		word_s6.det_neg   <= det_s5[DW-1];
		word_s6.singular  <= (det_s5 == '0);
		word_s6.det_field <= sat_entry(det_s5[DW-1], |det_shr[DW-1:ENTRY_W-1],
			det_shr[ENTRY_W-1:0]);
	end

	assign v_out = v_s6;
	assign word  = word_s6;

endmodule

// File: rtl/mi3_fifo.sv
module mi3_fifo import mi3_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  fe_word_t wdata,
	input  logic     pop,
	output fe_word_t rdata,
	output logic     empty
);

	fe_word_t       mem_q [QDEPTH];
	logic [QAW:0]   wr_q;
	logic [QAW:0]   rd_q;

	// pointers with wrap bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q[QAW-1:0]] <= wdata;
	end

	assign rdata = mem_q[rd_q[QAW-1:0]];
	assign empty = (wr_q == rd_q);

endmodule

// File: rtl/mi3_back.sv
module mi3_back import mi3_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  fe_word_t  qw,
	output logic      q_pop,
	output out_word_t res,
	output logic      empty,
	input  logic      pop
);

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

	state_t          state_q;
	logic [CNTW-1:0] cnt_q;
	out_word_t       out_q;
	logic            out_v_q;

	logic [DW-1:0]   dmag_q;
	logic            sing_q;
	entry_t          detf_q;

	logic            xfer;
	logic            load;
	logic            step;
	entry_t          lane_res [NCOF];
	out_word_t       res_d;

	assign xfer  = (state_q == S_DONE) && (!out_v_q || pop);
	assign load  = !q_empty && ((state_q == S_IDLE) || xfer);
	assign step  = (state_q == S_RUN);
	assign q_pop = load;

	// one restoring divider lane per inverse entry, one quotient bit a cycle
	for (genvar k = 0; k < NCOF; k++) begin : g_lane
		localparam int SRC = (k % 3) * 3 + k / 3;   // transposed cofactor

		logic signed [CW-1:0] c;
		logic [CW-1:0]        cmag;
		logic [NW-1:0]        num;
		logic                 ovf_d;
		logic [DW:0]          trial;
		logic                 ge;
		logic [DW-1:0]        rem_q;
		logic [ENTRY_W-1:0]   lo_q;
		logic [ENTRY_W-1:0]   quo_q;
		logic                 ovf_q;
		logic                 neg_q;

		always_comb begin
			c     = $signed(qw.cof[SRC]);
			cmag  = c[CW-1] ? CW'(-c) : CW'(c);
			num   = {cmag, (2*FRAC_BITS)'(0)};
			ovf_d = XW'(num[NW-1:ENTRY_W]) >= XW'(qw.det_mag);
			trial = {rem_q, lo_q[ENTRY_W-1]};
			ge    = trial >= (DW+1)'(dmag_q);
		end

		always_ff @(posedge clk) begin
			if (load) begin
				rem_q <= DW'(num[NW-1:ENTRY_W]);
				lo_q  <= num[ENTRY_W-1:0];
				quo_q <= '0;
				ovf_q <= ovf_d;
				neg_q <= c[CW-1] ^ qw.det_neg;
			end else if (step) begin
				rem_q <= ge ? DW'(trial - (DW+1)'(dmag_q)) : trial[DW-1:0];
				lo_q  <= lo_q << 1;
				quo_q <= {quo_q[ENTRY_W-2:0], ge};
			end
		end

		assign lane_res[k] = sat_entry(neg_q, ovf_q, quo_q);
	end

	// per-item fields
	always_ff @(posedge clk) begin
		if (load) begin
			dmag_q <= qw.det_mag;
			sing_q <= qw.singular;
			detf_q <= qw.det_field;
		end
	end

	// result assembly; singular gives zero entries
	always_comb begin
		res_d.inv00       = sing_q ? '0 : lane_res[0];
		res_d.inv01       = sing_q ? '0 : lane_res[1];
		res_d.inv02       = sing_q ? '0 : lane_res[2];
		res_d.inv10       = sing_q ? '0 : lane_res[3];
		res_d.inv11       = sing_q ? '0 : lane_res[4];
		res_d.inv12       = sing_q ? '0 : lane_res[5];
		res_d.inv20       = sing_q ? '0 : lane_res[6];
		res_d.inv21       = sing_q ? '0 : lane_res[7];
		res_d.inv22       = sing_q ? '0 : lane_res[8];
		res_d.determinant = detf_q;
		res_d.singular    = sing_q;
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			out_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			// output valid: set on transfer, cleared when popped
			if (xfer)
				out_v_q <= 1'b1;
			else if (pop && out_v_q)
				out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (load) begin
						cnt_q   <= '0;
						state_q <= qw.singular ? S_DONE : S_RUN;
					end
				end
				S_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNTW'(ENTRY_W - 1))
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (xfer) begin
						out_q   <= res_d;
						cnt_q   <= '0;
						if (load)
							state_q <= qw.singular ? S_DONE : S_RUN;
						else
							state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res   = out_q;
	assign empty = !out_v_q;

endmodule

// File: rtl/matrix_inverse_3x3.sv
// 3x3 matrix inverse by adjugate, signed Q16.16 in and out.
// The nine shared divider lanes retire one quotient bit per cycle and take a new
// matrix only once the last result has moved on; a singular matrix skips division.
// Up to 8 matrices may be in flight in the front pipeline and queue.
// Reset (arst_n, async, active low) empties pipeline, queue and output.
module matrix_inverse_3x3 import mi3_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  in_word_t  mat,
	input  logic      push,
	output logic      full,
	output out_word_t res,
	output logic      empty,
	input  logic      pop
);

	logic           accept;
	logic [OCW-1:0] occ_q;
	logic           fe_v;
	fe_word_t       fe_word;
	fe_word_t       fq_word;
	logic           fq_empty;
	logic           fq_pop;

	assign accept = push && !full;
	assign full   = (occ_q == OCW'(QDEPTH));

	// words between accept and back-end pickup; bounds queue fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			occ_q <= '0;
		else
			occ_q <= occ_q + OCW'(accept) - OCW'(fq_pop);
	end

	mi3_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.v_in   (accept),
		.mat    (mat),
		.v_out  (fe_v),
		.word   (fe_word)
	);

	mi3_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fe_v),
		.wdata  (fe_word),
		.pop    (fq_pop),
		.rdata  (fq_word),
		.empty  (fq_empty)
	);

	mi3_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (fq_empty),
		.qw      (fq_word),
		.q_pop   (fq_pop),
		.res     (res),
		.empty   (empty),
		.pop     (pop)
	);

	// queue holding a word means it was counted in flight
	a_queue_counted: assert property (@(posedge clk) disable iff (!arst_n)
		!fq_empty |-> (occ_q != '0))
		else $error("queue holds a word not counted in flight");

	// an accepted word is counted
	a_accept_counted: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (occ_q != '0))
		else $error("accepted word not counted");

	// singular result carries zero entries and zero determinant
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && res.singular) |->
		(res.inv00 == '0 && res.inv01 == '0 && res.inv02 == '0 &&
		 res.inv10 == '0 && res.inv11 == '0 && res.inv12 == '0 &&
		 res.inv20 == '0 && res.inv21 == '0 && res.inv22 == '0 &&
		 res.determinant == '0))
		else $error("singular result with nonzero fields");

endmodule
